// File: rtl/core/rtfd_pkg.sv
// ----------------------------------------------------------------------------
// rtfd_pkg
// Shared types and constants of the radar target frame decoder.
// ----------------------------------------------------------------------------
package rtfd_pkg;

   // Frame layout
   localparam int unsigned FRAME_BYTES = 30;
   localparam int unsigned SLOTS       = 3;
   localparam int unsigned SLOT_BYTES  = 8;
   localparam int unsigned DATA_BYTES  = SLOTS * SLOT_BYTES;
   localparam int unsigned DATA_START  = 4;
   localparam int unsigned SLOT_BITS   = SLOT_BYTES * 8;

   // Number of slots reported per frame (1 to SLOTS)
   localparam int unsigned TARGET_COUNT = 3;

   // Marker bytes
   localparam logic [7:0] HDR_LEAD  = 8'hAA;
   localparam logic [7:0] HDR_TRAIL = 8'hFF;
   localparam logic [7:0] FTR_LEAD  = 8'h55;
   localparam logic [7:0] FTR_TRAIL = 8'hCC;

   // Byte positions in a frame
   localparam logic [4:0] POS_FIRST_TYPE  = 5'd2;
   localparam logic [4:0] POS_DATA_FIRST  = 5'(DATA_START);
   localparam logic [4:0] POS_DATA_LAST   = 5'(DATA_START + DATA_BYTES - 1);
   localparam logic [4:0] POS_FOOTER_LEAD = 5'(FRAME_BYTES - 2);
   localparam logic [4:0] POS_FOOTER_LAST = 5'(FRAME_BYTES - 1);

   // One slot is 8 bytes, little-endian: x, y, speed, resolution
   typedef logic [SLOT_BITS-1:0] slot_type;

   // All target slots of one frame
   typedef logic [SLOTS-1:0][SLOT_BITS-1:0] frame_type;

   // One decoded target result
   typedef struct packed {
      logic [1:0]         target_index;
      logic signed [15:0] x_pos;
      logic [14:0]        y_dist;
      logic signed [15:0] target_speed;
      logic [15:0]        resolution;
      logic               present;
      logic               last;
   } result_type;

   // Sign-magnitude to two's complement
   function automatic logic signed [15:0] sm_decode(input logic [15:0] raw);
      logic [15:0] mag;
      mag = {1'b0, raw[14:0]};
      if (raw[15]) begin
         return 16'(16'd0 - mag);
      end
      return mag;
   endfunction

endpackage

// File: rtl/core/rtfd_front.sv
// ----------------------------------------------------------------------------
// rtfd_front
// Hunts for the frame header, collects target bytes and checks the footer.
// A frame with a good footer is pushed to the frame queue.
// ----------------------------------------------------------------------------
module rtfd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_valid,
   input  logic [7:0]         rx_byte,
   input  logic               queue_full,
   output logic               frame_push,
   output rtfd_pkg::frame_type frame_data
);

   logic       accept;
   logic       saw_lead_ff, saw_lead_in;
   logic       in_frame_ff, in_frame_in;
   logic [4:0] pos_ff, pos_in;
   logic [7:0] footer_first_ff, footer_first_in;
   logic [7:0] data_ff [rtfd_pkg::DATA_BYTES];
   logic       is_data;
   logic       good_footer;

   assign accept  = byte_valid & ~queue_full;
   assign is_data = (pos_ff >= rtfd_pkg::POS_DATA_FIRST) && (pos_ff <= rtfd_pkg::POS_DATA_LAST);
   assign good_footer = (footer_first_ff == rtfd_pkg::FTR_LEAD) &&
                        (rx_byte == rtfd_pkg::FTR_TRAIL);

   // Advance the hunt and frame position
   always_comb begin
      saw_lead_in     = saw_lead_ff;
      in_frame_in     = in_frame_ff;
      pos_in          = pos_ff;
      footer_first_in = footer_first_ff;
      frame_push      = 1'b0;
      if (accept) begin
         if (!in_frame_ff) begin
            if (saw_lead_ff && rx_byte == rtfd_pkg::HDR_TRAIL) begin
               in_frame_in = 1'b1;
               saw_lead_in = 1'b0;
               pos_in      = rtfd_pkg::POS_FIRST_TYPE;
            end else begin
               saw_lead_in = (rx_byte == rtfd_pkg::HDR_LEAD);
            end
         end else if (pos_ff < rtfd_pkg::POS_FIRST_TYPE ||
                      pos_ff > rtfd_pkg::POS_FOOTER_LAST) begin
            in_frame_in = 1'b0;
            saw_lead_in = 1'b0;
            pos_in      = '0;
         end else if (pos_ff == rtfd_pkg::POS_FOOTER_LAST) begin
            frame_push  = good_footer;
            in_frame_in = 1'b0;
            saw_lead_in = 1'b0;
            pos_in      = '0;
         end else begin
            if (pos_ff == rtfd_pkg::POS_FOOTER_LEAD) begin
               footer_first_in = rx_byte;
            end
            pos_in = pos_ff + 5'd1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         saw_lead_ff     <= 1'b0;
         in_frame_ff     <= 1'b0;
         pos_ff          <= '0;
         footer_first_ff <= '0;
      end else begin
         saw_lead_ff     <= saw_lead_in;
         in_frame_ff     <= in_frame_in;
         pos_ff          <= pos_in;
         footer_first_ff <= footer_first_in;
      end
   end

   // Shift target bytes in; after the last data byte the first one sits at entry 0
   always_ff @(posedge clock) begin
      if (accept && in_frame_ff && is_data) begin
         for (int i = 0; i < rtfd_pkg::DATA_BYTES - 1; i++) begin
            data_ff[i] <= data_ff[i+1];
         end
         data_ff[rtfd_pkg::DATA_BYTES-1] <= rx_byte;
      end
   end

   // Pack bytes into slots
   always_comb begin
      for (int s = 0; s < rtfd_pkg::SLOTS; s++) begin
         for (int k = 0; k < rtfd_pkg::SLOT_BYTES; k++) begin
            frame_data[s][k*8 +: 8] = data_ff[s*rtfd_pkg::SLOT_BYTES + k];
         end
      end
   end

endmodule

// File: rtl/core/rtfd_queue.sv
// ----------------------------------------------------------------------------
// rtfd_queue
// Two-entry queue of complete frames between the front and back parts.
// ----------------------------------------------------------------------------
module rtfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rtfd_pkg::frame_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output rtfd_pkg::frame_type pop_data
);

   rtfd_pkg::frame_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed frames
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/rtfd_back.sv
// ----------------------------------------------------------------------------
// rtfd_back
// Takes frames from the queue and emits one decoded target per cycle into
// an output register while that register is empty or being popped.
// ----------------------------------------------------------------------------
module rtfd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  rtfd_pkg::frame_type  queue_data,
   output logic                 queue_pop,
   input  logic                 out_pop,
   output logic                 out_valid,
   output rtfd_pkg::result_type out_data
);

   localparam logic [1:0] LastSlot = 2'(rtfd_pkg::TARGET_COUNT - 1);

   logic                 busy_ff, busy_in;
   logic [1:0]           slot_ff, slot_in;
   rtfd_pkg::frame_type  frame_ff;
   logic                 out_valid_ff, out_valid_in;
   rtfd_pkg::result_type out_ff, result;
   rtfd_pkg::slot_type   raw;
   logic [15:0]          raw_y, raw_r, res;
   logic                 out_ready, emit;

   assign out_ready = ~out_valid_ff | out_pop;
   assign emit      = busy_ff & out_ready;
   assign queue_pop = ~busy_ff & ~queue_empty;

   // Decode the current slot
   always_comb begin
      raw   = frame_ff[slot_ff];
      raw_y = raw[31:16];
      raw_r = raw[63:48];
      res   = raw_y[15] ? raw_r : 16'd0;
      result.target_index = slot_ff;
      result.x_pos        = rtfd_pkg::sm_decode(raw[15:0]);
      result.y_dist       = raw_y[14:0];
      result.target_speed = rtfd_pkg::sm_decode(raw[47:32]);
      result.resolution   = res;
      result.present      = (res != 16'd0);
      result.last         = (slot_ff == LastSlot);
   end

   // Step through slots and hold the output register
   always_comb begin
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff & ~out_pop;
      if (queue_pop) begin
         busy_in = 1'b1;
         slot_in = '0;
      end else if (emit) begin
         out_valid_in = 1'b1;
         slot_in      = slot_ff + 2'd1;
         if (slot_ff == LastSlot) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load frame and result payloads
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         frame_ff <= queue_data;
      end
      if (emit) begin
         out_ff <= result;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// File: rtl/core/radar_target_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// radar_target_frame_decoder_core
// Decodes radar target frames from a byte stream into per-target results.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while req_full is low. The front part
// hunts for the header AA FF, collects the 30-byte frame and checks the footer
// 55 CC; a good frame goes into a two-frame queue and a bad one is dropped. The
// back part emits the three target results of a frame one per cycle through an
// output register while it is empty or being popped. req_full rises only while
// both queue slots hold frames that the result side has not yet drained, so
// with rsp_pop held high bytes are taken every cycle. No clearing pass is
// needed after reset.
module radar_target_frame_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [1:0]         rsp_target_index,
   output logic signed [15:0] rsp_x_pos,
   output logic [14:0]        rsp_y_dist,
   output logic signed [15:0] rsp_target_speed,
   output logic [15:0]        rsp_resolution,
   output logic               rsp_present,
   output logic               rsp_last
);

   logic                 q_push, q_full, q_pop, q_empty, out_valid;
   rtfd_pkg::frame_type  q_in, q_out;
   rtfd_pkg::result_type out_data;

   rtfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_push),
      .rx_byte    (req_rx_byte),
      .queue_full (q_full),
      .frame_push (q_push),
      .frame_data (q_in)
   );

   rtfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   rtfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .queue_data  (q_out),
      .queue_pop   (q_pop),
      .out_pop     (rsp_pop),
      .out_valid   (out_valid),
      .out_data    (out_data)
   );

   // Drive the port side
   assign req_full         = q_full;
   assign rsp_empty        = ~out_valid;
   assign rsp_target_index = out_data.target_index;
   assign rsp_x_pos        = out_data.x_pos;
   assign rsp_y_dist       = out_data.y_dist;
   assign rsp_target_speed = out_data.target_speed;
   assign rsp_resolution   = out_data.resolution;
   assign rsp_present      = out_data.present;
   assign rsp_last         = out_data.last;

   // Never push a frame into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("frame pushed into full queue");

   // The last flag marks exactly the final slot
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last == (rsp_target_index == 2'(rtfd_pkg::TARGET_COUNT - 1))))
      else $error("last flag does not match slot index");

   // A present target reports a nonzero resolution
   a_behind: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_present) |-> (rsp_resolution != 16'd0))
      else $error("present target with zero resolution");

   // A taken non-final result is followed by the next slot of the same frame
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last) ##1 !rsp_empty |->
         rsp_target_index == $past(rsp_target_index) + 2'd1)
      else $error("target slots out of order");

endmodule
